// File: hdl/cfba_pkg.sv
// ----------------------------------------------------------------------------
// cfba_pkg
// Shared types and constants of the chunked fixed block allocator: payload
// structs, command and status codes, register indexes and the FSM states.
// ----------------------------------------------------------------------------
package cfba_pkg;

  // Geometry of the chunk slots
  localparam int NUM_CHUNKS = 8;
  localparam int MAX_BLOCKS = 64;
  localparam int CHUNK_W    = 3;
  localparam int BLOCK_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int ADDR_W     = CHUNK_W + BLOCK_W;
  localparam int RAM_DEPTH  = NUM_CHUNKS * MAX_BLOCKS;
  localparam int ACTIVE_W   = 4;
  localparam int OFFSET_W   = 17;
  localparam int STATUS_W   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int BPC_W      = 7;
  localparam int BBYTES_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_CHUNK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES      = 2'd1;

  localparam logic [BPC_W-1:0]    BPC_RESET    = 7'd64;
  localparam logic [BBYTES_W-1:0] BBYTES_RESET = 8'd16;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [CHUNK_W-1:0] chunk_index;
    logic [BLOCK_W-1:0] block_index;
  } cfba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHUNK_W-1:0]  got_chunk;
    logic [BLOCK_W-1:0]  got_block;
    logic [OFFSET_W-1:0] byte_offset;
    logic [ACTIVE_W-1:0] chunks_active;
  } cfba_out_t;

  // Access request to the next-free link memory
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [BLOCK_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } cfba_ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_READ,
    S_POP,
    S_COMMIT
  } cfba_state_t;

endpackage

// File: hdl/chunked_fixed_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// chunked_fixed_block_allocator_unit
// Fixed-size block allocator over eight chunk slots with embedded free lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid / in_stall / in_data) carry an allocate or a free
//   command. Every item yields exactly one result item on out_valid /
//   out_stall / out_data: status, allocated chunk and block, byte offset and
//   the number of active chunks after the command.
//   One item is worked on at a time. An allocate served from an active chunk
//   reads the link behind the chunk's head on acceptance and then pops the
//   head block into the result register; a free goes straight to its commit
//   step. An allocate that activates a new chunk first builds its free list,
//   one link per cycle (count clamped to 1..64), then reads the head link and
//   pops. A new item is taken only after the result register is loaded. The
//   link memory has a single write and a single read port.
//   The input side is free to take a new item while the previous result
//   waits in the output register; a stalled receiver holds the block in its
//   final step until the output register drains.
//   Configuration writes (cfg_valid / cfg_ready / cfg_index / cfg_data) are
//   always taken and belong to idle periods only.
//   Reset (rst_n low, synchronous) deactivates all chunks and loads the
//   registers with 64 blocks per chunk and 16 bytes per block; the link
//   memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module chunked_fixed_block_allocator_unit import cfba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cfba_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cfba_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfba_state_t state_r, state_nxt;

  cfba_in_t           req_r, req_nxt;
  logic [CHUNK_W-1:0] pick_r, pick_nxt;
  logic [BLOCK_W-1:0] walk_r, walk_nxt;
  logic [CHUNK_W-1:0] cur_r, cur_nxt;
  logic [BLOCK_W-1:0] head_r  [NUM_CHUNKS];
  logic [BLOCK_W-1:0] head_nxt[NUM_CHUNKS];
  logic [COUNT_W-1:0] count_r  [NUM_CHUNKS];
  logic [COUNT_W-1:0] count_nxt[NUM_CHUNKS];
  logic [NUM_CHUNKS-1:0] active_r, active_nxt;
  logic [BPC_W-1:0]    bpc_r;
  logic [BBYTES_W-1:0] bbytes_r;
  logic      out_valid_r, out_valid_nxt;
  cfba_out_t out_data_r, out_data_nxt;

  cfba_ram_req_t      ram_req;
  logic [BLOCK_W-1:0] ram_rdata;

  logic [COUNT_W-1:0] eff_n;
  logic               out_free;
  logic               cur_ok;
  logic               used_found;
  logic [CHUNK_W-1:0] used_idx;
  logic               idle_found;
  logic [CHUNK_W-1:0] idle_idx;
  logic [CHUNK_W-1:0] alloc_pick;
  logic               walk_last;

  cfba_nf_ram u_nf_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rdata   (ram_rdata)
  );

  // Clamp the block count to 1..MAX_BLOCKS
  always_comb begin
    if (bpc_r == '0) begin
      eff_n = COUNT_W'(1);
    end else if (bpc_r > BPC_W'(MAX_BLOCKS)) begin
      eff_n = COUNT_W'(MAX_BLOCKS);
    end else begin
      eff_n = bpc_r;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign walk_last = (({1'b0, walk_r} + COUNT_W'(1)) == eff_n);

  // Find the lowest chunk with room and the lowest inactive chunk
  always_comb begin
    used_found = 1'b0;
    used_idx   = '0;
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (active_r[i] && count_r[i] != '0) begin
        used_found = 1'b1;
        used_idx   = CHUNK_W'(i);
      end
      if (!active_r[i]) begin
        idle_found = 1'b1;
        idle_idx   = CHUNK_W'(i);
      end
    end
  end

  assign cur_ok     = active_r[cur_r] && count_r[cur_r] != '0;
  assign alloc_pick = cur_ok ? cur_r : used_idx;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_FREE) begin
            state_nxt = S_COMMIT;
          end else if (cur_ok || used_found) begin
            state_nxt = S_POP;
          end else if (idle_found) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_WALK: begin
        if (walk_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_POP;
      end
      S_POP, S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and memory requests per state
  always_comb begin
    logic [BLOCK_W-1:0] pop_blk;
    logic [COUNT_W-1:0] new_cnt;
    logic               bad;
    logic               pair_found;
    logic [CHUNK_W-1:0] pair_idx;
    logic [CHUNK_W-1:0] hi_idx;
    logic [CHUNK_W-1:0] lo_idx;

    req_nxt    = req_r;
    pick_nxt   = pick_r;
    walk_nxt   = walk_r;
    cur_nxt    = cur_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    active_nxt = active_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_req    = '0;

    pop_blk    = head_r[pick_r];
    new_cnt    = (count_r[req_r.chunk_index] == '1) ? '1
               : count_r[req_r.chunk_index] + COUNT_W'(1);
    bad        = !active_r[req_r.chunk_index] || ({1'b0, req_r.block_index} >= eff_n);
    pair_found = 1'b0;
    pair_idx   = '0;
    for (int j = NUM_CHUNKS - 1; j >= 0; j--) begin
      if (CHUNK_W'(j) != req_r.chunk_index && active_r[j] && count_r[j] >= eff_n) begin
        pair_found = 1'b1;
        pair_idx   = CHUNK_W'(j);
      end
    end
    hi_idx = (pair_idx > req_r.chunk_index) ? pair_idx : req_r.chunk_index;
    lo_idx = (pair_idx > req_r.chunk_index) ? req_r.chunk_index : pair_idx;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.cmd == CMD_ALLOC) begin
            if (cur_ok || used_found) begin
              // Fetch the link behind the head of the chosen chunk
              pick_nxt      = alloc_pick;
              ram_req.re    = 1'b1;
              ram_req.raddr = {alloc_pick, head_r[alloc_pick]};
            end else if (idle_found) begin
              pick_nxt = idle_idx;
              walk_nxt = '0;
            end
          end
        end
      end
      S_WALK: begin
        // Build the fresh list in order, one link per cycle
        ram_req.we    = 1'b1;
        ram_req.waddr = {pick_r, walk_r};
        ram_req.wdata = walk_r + BLOCK_W'(1);
        walk_nxt      = walk_r + BLOCK_W'(1);
        if (walk_last) begin
          head_nxt[pick_r]   = '0;
          count_nxt[pick_r]  = eff_n;
          active_nxt[pick_r] = 1'b1;
        end
      end
      S_READ: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = {pick_r, head_r[pick_r]};
      end
      S_POP: begin
        // Pop the head block and report it
        if (out_free) begin
          head_nxt[pick_r]  = ram_rdata;
          count_nxt[pick_r] = count_r[pick_r] - COUNT_W'(1);
          cur_nxt           = pick_r;
          out_valid_nxt     = 1'b1;
          out_data_nxt.status        = ST_OK;
          out_data_nxt.got_chunk     = pick_r;
          out_data_nxt.got_block     = pop_blk;
          out_data_nxt.byte_offset   = OFFSET_W'({pick_r, pop_blk}) * OFFSET_W'(bbytes_r);
          out_data_nxt.chunks_active = ACTIVE_W'($countones(active_r));
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (req_r.cmd == CMD_ALLOC) begin
            out_data_nxt.status = ST_NO_SPACE;
          end else if (bad) begin
            out_data_nxt.status = ST_BAD_FREE;
          end else begin
            // Push the block, then drop the higher of two empty chunks
            ram_req.we    = 1'b1;
            ram_req.waddr = {req_r.chunk_index, req_r.block_index};
            ram_req.wdata = head_r[req_r.chunk_index];
            head_nxt[req_r.chunk_index]  = req_r.block_index;
            count_nxt[req_r.chunk_index] = new_cnt;
            if (new_cnt >= eff_n && pair_found) begin
              active_nxt[hi_idx] = 1'b0;
              head_nxt[hi_idx]   = '0;
              count_nxt[hi_idx]  = '0;
              cur_nxt            = lo_idx;
            end
            out_data_nxt.status = ST_OK;
          end
          out_data_nxt.chunks_active = ACTIVE_W'($countones(active_nxt));
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      cur_r       <= '0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      cur_r       <= cur_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r    <= BPC_RESET;
      bbytes_r <= BBYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCKS_PER_CHUNK: bpc_r    <= cfg_data[BPC_W-1:0];
        CFG_BLOCK_BYTES:      bbytes_r <= cfg_data[BBYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pick_r     <= pick_nxt;
    walk_r     <= walk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// File: hdl/cfba_nf_ram.sv
// ----------------------------------------------------------------------------
// cfba_nf_ram
// Next-free link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfba_nf_ram import cfba_pkg::*; (
  input  logic               clk,
  input  cfba_ram_req_t      ram_req,
  output logic [BLOCK_W-1:0] rdata
);

  logic [BLOCK_W-1:0] mem [RAM_DEPTH];
  logic [BLOCK_W-1:0] rdata_r;

  // Write link entry
  always_ff @(posedge clk) begin
    if (ram_req.we) begin
      mem[ram_req.waddr] <= ram_req.wdata;
    end
  end

  // Read link entry, hold data until the next read
  always_ff @(posedge clk) begin
    if (ram_req.re) begin
      rdata_r <= mem[ram_req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: tb/sv/cfba_outcome_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfba_outcome_checker
// Watches the request, result and register channels of the chunked fixed
// block allocator, keeps its own copy of the chunk free lists and checks
// every result item field by field against the predicted allocator outcome.
// ----------------------------------------------------------------------------
module cfba_outcome_checker import cfba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  cfba_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  cfba_out_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  drain_check,
  output logic [31:0]           pending,
  output logic [31:0]           fail_count
);

  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  // Shadow allocator state
  logic [BLOCK_W-1:0]  link_ram [RAM_DEPTH];
  logic [BLOCK_W-1:0]  list_head [NUM_CHUNKS];
  logic [COUNT_W-1:0]  list_count [NUM_CHUNKS];
  logic                slot_live [NUM_CHUNKS];
  int                  last_slot;
  logic [BPC_W-1:0]    cur_bpc;
  logic [BBYTES_W-1:0] cur_bbytes;

  cfba_out_t   awaited_outcomes [$];
  int unsigned mismatches = 0;

  // Apply one command to the shadow state and return its outcome
  function automatic cfba_out_t run_allocator_cmd(cfba_in_t req);
    cfba_out_t res;
    int        n;
    int        pick;
    int        blk;
    int        ci;
    int        hi;
    int        lo;
    int        live;
    bit        merged;
    res = '0;
    n = (cur_bpc == 0) ? 1 : ((cur_bpc > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_bpc));
    if (req.cmd == CMD_ALLOC) begin
      // prefer the last used slot, then the lowest slot with room
      pick = NUM_CHUNKS;
      if (slot_live[last_slot] && list_count[last_slot] > 0) pick = last_slot;
      for (int i = 0; i < NUM_CHUNKS && pick == NUM_CHUNKS; i++) begin
        if (slot_live[i] && list_count[i] > 0) pick = i;
      end
      // open the lowest idle slot with an in-order list
      for (int i = 0; i < NUM_CHUNKS && pick == NUM_CHUNKS; i++) begin
        if (!slot_live[i]) begin
          for (int b = 0; b < n; b++) link_ram[i * MAX_BLOCKS + b] = BLOCK_W'(b + 1);
          list_head[i]  = '0;
          list_count[i] = COUNT_W'(n);
          slot_live[i]  = 1'b1;
          pick = i;
        end
      end
      if (pick == NUM_CHUNKS) begin
        res.status = ST_NO_SPACE;
      end else begin
        blk = int'(list_head[pick]);
        list_head[pick]  = link_ram[pick * MAX_BLOCKS + blk];
        list_count[pick] = list_count[pick] - 1'b1;
        last_slot        = pick;
        res.status      = ST_OK;
        res.got_chunk   = CHUNK_W'(pick);
        res.got_block   = BLOCK_W'(blk);
        res.byte_offset = OFFSET_W'((pick * MAX_BLOCKS + blk) * int'(cur_bbytes));
      end
    end else begin
      ci = int'(req.chunk_index);
      if (!slot_live[ci] || req.block_index >= n) begin
        res.status = ST_BAD_FREE;
      end else begin
        // push the block; a repeated free is pushed again
        link_ram[ci * MAX_BLOCKS + req.block_index] = list_head[ci];
        list_head[ci] = req.block_index;
        if (list_count[ci] < COUNT_MAX) list_count[ci] = list_count[ci] + 1'b1;
        // keep at most one fully free slot: drop the higher of a pair
        merged = 1'b0;
        if (list_count[ci] >= n) begin
          for (int j = 0; j < NUM_CHUNKS; j++) begin
            if (!merged && j != ci && slot_live[j] && list_count[j] >= n) begin
              hi = (j > ci) ? j : ci;
              lo = (j > ci) ? ci : j;
              slot_live[hi]  = 1'b0;
              list_head[hi]  = '0;
              list_count[hi] = '0;
              last_slot = lo;
              merged = 1'b1;
            end
          end
        end
        res.status = ST_OK;
      end
    end
    live = 0;
    for (int i = 0; i < NUM_CHUNKS; i++) if (slot_live[i]) live++;
    res.chunks_active = ACTIVE_W'(live);
    return res;
  endfunction

  task automatic match_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cfba_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < RAM_DEPTH; i++) link_ram[i] = '0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        list_head[i]  = '0;
        list_count[i] = '0;
        slot_live[i]  = 1'b0;
      end
      last_slot  = 0;
      cur_bpc    = BPC_RESET;
      cur_bbytes = BBYTES_RESET;
      awaited_outcomes.delete();
    end else begin
      // register writes land when taken; the user must keep them to while idle, the checker does not enforce it
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCKS_PER_CHUNK: cur_bpc = cfg_data[BPC_W-1:0];
          CFG_BLOCK_BYTES:      cur_bbytes = cfg_data[BBYTES_W-1:0];
          default: ;
        endcase
      end
      // retire the oldest outcome before queueing a new one
      if (out_valid && !out_stall) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result item with no request outstanding: status %0d", out_data.status);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          match_field("status", 32'(want.status), 32'(out_data.status));
          match_field("got_chunk", 32'(want.got_chunk), 32'(out_data.got_chunk));
          match_field("got_block", 32'(want.got_block), 32'(out_data.got_block));
          match_field("byte_offset", 32'(want.byte_offset), 32'(out_data.byte_offset));
          match_field("chunks_active", 32'(want.chunks_active),
                      32'(out_data.chunks_active));
        end
      end
      if (in_valid && !in_stall) awaited_outcomes.push_back(run_allocator_cmd(in_data));
      if (drain_check && awaited_outcomes.size() != 0) begin
        $error("%0d result items never arrived", awaited_outcomes.size());
        mismatches += awaited_outcomes.size();
        awaited_outcomes.delete();
      end
    end
    pending    <= awaited_outcomes.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/sv/chunked_fixed_block_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_fixed_block_allocator_unit_tb
// Drives allocate and free items into the allocator under random gaps and
// result stalls, walks it through several register settings and reports
// the verdict from the outcome checker's failure count.
// ----------------------------------------------------------------------------
module chunked_fixed_block_allocator_unit_tb;
  import cfba_pkg::*;

  localparam int RAND_PHASES    = 22;
  localparam int NOISE_PCT      = 15;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 5000;

  // indexes that hold no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic [BLOCK_W-1:0] blk;
  } block_ref_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  cfba_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  cfba_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  drain_check;
  logic [31:0]           pending;
  logic [31:0]           fail_count;

  bit          calm    = 1'b0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_on  = 1'b0;
  int unsigned quiet_cycles = 0;

  logic       issued_cmds [$];
  block_ref_t held_blocks [$];

  chunked_fixed_block_allocator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfba_outcome_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .drain_check (drain_check),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Track live blocks so most frees name a block that was handed out
  always @(posedge clk) begin
    logic was_alloc;
    if (rst_n) begin
      if (out_valid && !out_stall && issued_cmds.size() != 0) begin
        was_alloc = (issued_cmds.pop_front() == CMD_ALLOC);
        if (was_alloc && out_data.status == ST_OK)
          held_blocks.push_back({out_data.got_chunk, out_data.got_block});
      end
      if (in_valid && !in_stall) issued_cmds.push_back(in_data.cmd);
    end
  end

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: stall bursts, free-running stretches, one long hold-off
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_req) begin
        out_stall <= 1'b1;
        hold_on = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        hold_on  = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 25)) @(posedge clk);
      end
    end
  end

  function automatic cfba_in_t make_req(logic cmd, int chunk, int blk);
    cfba_in_t item;
    item.cmd         = cmd;
    item.chunk_index = CHUNK_W'(chunk);
    item.block_index = BLOCK_W'(blk);
    return item;
  endfunction

  // Mostly well-formed traffic: allocate, or free a block still held
  function automatic cfba_in_t next_request(int alloc_pct);
    cfba_in_t item;
    int       pos;
    item = ($bits(cfba_in_t))'($urandom_range(0, 1023));
    if ($urandom_range(0, 99) < NOISE_PCT) return item;
    if (held_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
      item.cmd = CMD_ALLOC;
    end else begin
      pos = $urandom_range(0, held_blocks.size() - 1);
      item.cmd         = CMD_FREE;
      item.chunk_index = held_blocks[pos].chunk;
      item.block_index = held_blocks[pos].blk;
      held_blocks.delete(pos);
    end
    return item;
  endfunction

  // Offer one item, with an optional gap, and hold it until taken
  task automatic issue(cfba_in_t item);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every outstanding result item
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] bpc, logic [CFG_DATA_W-1:0] bbytes,
                              bit spare);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BLOCKS_PER_CHUNK;
    cfg_data  <= bpc;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_BLOCK_BYTES;
    cfg_data  <= bbytes;
    do @(posedge clk); while (!cfg_ready);
    if (spare) begin
      cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
      cfg_data  <= CFG_DATA_W'($urandom_range(0, 255));
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int               n_items;
    int               alloc_pct;
    logic [BPC_W-1:0] bpc7;
    logic [7:0]       bbytes;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_BLOCKS_PER_CHUNK;
    cfg_data    <= '0;
    drain_check <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // One block per chunk: fill all slots, run out, bad and repeated frees,
    // merge of two fully free slots, reuse of a dropped slot
    program_regs(8'd1, 8'd255, 1'b0);
    repeat (8) issue(make_req(CMD_ALLOC, 0, 0));
    issue(make_req(CMD_ALLOC, 0, 0));
    issue(make_req(CMD_FREE, 7, 63));
    issue(make_req(CMD_FREE, 3, 0));
    issue(make_req(CMD_FREE, 5, 0));
    issue(make_req(CMD_FREE, 3, 0));
    repeat (3) issue(make_req(CMD_ALLOC, 0, 0));
    issue(make_req(CMD_FREE, 5, 0));

    // Zero block count acts as one, zero block size gives zero offsets
    wait_drained();
    program_regs(8'd0, 8'd0, 1'b0);
    issue(make_req(CMD_ALLOC, 0, 0));
    issue(make_req(CMD_FREE, 5, 0));

    // Oversized block count acts as the maximum, applied to live slots
    wait_drained();
    program_regs(8'd127, 8'd16, 1'b1);
    issue(make_req(CMD_FREE, 5, 40));
    issue(make_req(CMD_FREE, 2, 63));
    issue(make_req(CMD_ALLOC, 0, 0));

    // Hammer one block of the top slot until its free count saturates
    gaps_on = 1'b0;
    repeat (130) issue(make_req(CMD_FREE, 7, 0));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      calm    = (ph >= RAND_PHASES - 2);
      gaps_on = !calm && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: bpc7 = BPC_W'($urandom_range(1, 4));
        4, 5:       bpc7 = BPC_W'($urandom_range(5, 16));
        6:          bpc7 = BPC_W'(MAX_BLOCKS);
        7:          bpc7 = BPC_W'($urandom_range(MAX_BLOCKS + 1, 127));
        8:          bpc7 = '0;
        default:    bpc7 = BPC_W'($urandom_range(17, MAX_BLOCKS - 1));
      endcase
      case ($urandom_range(0, 5))
        0:       bbytes = 8'd0;
        1:       bbytes = 8'd255;
        default: bbytes = 8'($urandom_range(1, 254));
      endcase
      program_regs({$urandom_range(0, 3) == 0, bpc7}, bbytes, $urandom_range(0, 3) == 0);
      // start the long hold-off before offering this phase's items
      if (ph == 1) begin
        hold_req = 1'b1;
        wait (hold_on);
      end
      // fill-heavy, balanced or drain-heavy phase
      case ($urandom_range(0, 2))
        0:       alloc_pct = 85;
        1:       alloc_pct = 55;
        default: alloc_pct = 20;
      endcase
      n_items = $urandom_range(40, 70);
      repeat (n_items) issue(next_request(alloc_pct));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
hdl/cfba_pkg.sv
hdl/cfba_nf_ram.sv
hdl/chunked_fixed_block_allocator_unit.sv
tb/sv/cfba_outcome_checker.sv
tb/sv/chunked_fixed_block_allocator_unit_tb.sv
